### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge of clk, ignored while rst is high.
`define RPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked on every rising edge of clk, reset included.
`define RPI_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define RPI_ASSERT(lbl, prop)
`define RPI_ASSERT_NORST(lbl, prop)
`endif
`endif

### rtl/rpi_pkg.sv
package rpi_pkg;

  // Fixed-point format and square-root depth.
  localparam int FracBits  = 16;
  localparam int SqrtIter  = 16;
  localparam int SqrtExtra = (SqrtIter > 18) ? SqrtIter - 18 : 0;
  localparam int SqrtTop   = 17 + SqrtExtra;
  localparam int RootW     = SqrtTop + 1;
  localparam int SqW       = 2 * SqrtTop + 3;

  // Dot products at or below this magnitude count as parallel.
  localparam longint ParEps = (longint'(1) << (2 * FracBits)) / 1000000;

  // Long dividers: dividend, divisor and quotient widths, and latency.
  localparam int DivNW  = 80;
  localparam int DivDW  = 40;
  localparam int QW     = 32;
  localparam int DivLat = QW + 2;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_t;

endpackage

### rtl/rpi_div.sv
module rpi_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rpi_pkg::DivNW-1:0]        dividend,
  input  logic [rpi_pkg::DivDW-1:0]        divisor,
  input  logic                             neg,
  output logic signed [rpi_pkg::QW-1:0]    quot
);

  localparam int NW = rpi_pkg::DivNW;
  localparam int DW = rpi_pkg::DivDW;
  localparam int QW = rpi_pkg::QW;

  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [DW-1:0] dvs  [0:QW];
  logic          ovf  [0:QW];
  logic          ng   [0:QW];
  logic [DW:0]   shv  [0:QW-1];
  logic          take [0:QW-1];

  // One restoring step per stage: shift in the next dividend bit, then
  // compare and subtract.
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      shv[k]  = {rem[k], low[k][QW-1]};
      take[k] = (shv[k] >= {1'b0, dvs[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A quotient of 2^32 or more saturates, so only the low 32 bits are worked out.
      rem[0] <= dividend[QW +: DW];
      low[0] <= dividend[QW-1:0];
      q[0]   <= '0;
      dvs[0] <= divisor;
      ovf[0] <= (dividend[NW-1:QW] >= (NW-QW)'(divisor));
      ng[0]  <= neg;
      for (int k = 0; k < QW; k++) begin
        rem[k+1] <= take[k] ? DW'(shv[k] - {1'b0, dvs[k]}) : DW'(shv[k]);
        low[k+1] <= low[k] << 1;
        q[k+1]   <= {q[k][QW-2:0], take[k]};
        dvs[k+1] <= dvs[k];
        ovf[k+1] <= ovf[k];
        ng[k+1]  <= ng[k];
      end
      if (ng[QW]) begin
        quot <= (ovf[QW] || q[QW][QW-1]) ? {1'b1, {(QW-1){1'b0}}} : $signed(-q[QW]);
      end else begin
        quot <= (ovf[QW] || q[QW][QW-1]) ? {1'b0, {(QW-1){1'b1}}} : $signed(q[QW]);
      end
    end
  end

endmodule

### rtl/ray_plane_intersect_core.sv
// Ray/plane intersection in signed Q16.16. One ray enters per clock while in_stall is low,
// and every ray gives exactly one result beat. Most of the pipeline depth lies in two
// 34-stage long divider steps in series, one for the distance t and one pair for the (u, v)
// plane coordinates, each resolving one quotient bit per restoring stage. The whole pipeline
// advances together; it holds only when a result waits at the output and another one is
// ready behind it, and in_stall is high exactly then. The plane must be written through the
// cfg port only while no ray is in flight; the block itself does not enforce this. The u axis,
// its length (a 16-stage square root) and the v axis are rebuilt from the registers well
// before any new ray needs them.
`include "assert_macros.svh"

module ray_plane_intersect_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   origin_x,
  input  logic signed [31:0]                   origin_y,
  input  logic signed [31:0]                   origin_z,
  input  logic signed [17:0]                   dir_x,
  input  logic signed [17:0]                   dir_y,
  input  logic signed [17:0]                   dir_z,
  input  logic signed [31:0]                   t_min,
  input  logic signed [31:0]                   t_max,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit_found,
  output logic signed [31:0]                   hit_distance,
  output logic signed [31:0]                   point_x,
  output logic signed [31:0]                   point_y,
  output logic signed [31:0]                   point_z,
  output logic signed [17:0]                   face_normal_x,
  output logic signed [17:0]                   face_normal_y,
  output logic signed [17:0]                   face_normal_z,
  output logic                                 front_face,
  output logic signed [31:0]                   coord_u,
  output logic signed [31:0]                   coord_v,
  input  logic                                 cfg_we,
  input  logic [rpi_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [rpi_pkg::CfgDataW-1:0]         cfg_data
);

  localparam int FB     = rpi_pkg::FracBits;
  localparam int DivLat = rpi_pkg::DivLat;
  localparam int RootW  = rpi_pkg::RootW;
  localparam int SqW    = rpi_pkg::SqW;
  localparam int NIter  = rpi_pkg::SqrtIter;
  localparam int WW     = 38 - FB;
  localparam int PwW    = 33 + WW;
  localparam int DvW    = PwW + 2;
  localparam logic signed [37:0] EpsPos = 38'(rpi_pkg::ParEps);
  localparam logic signed [37:0] EpsNeg = -38'(rpi_pkg::ParEps);

  typedef struct packed {
    logic               parallel;
    logic               den_neg;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
  } side_t;

  typedef struct packed {
    logic               keep;
    logic               den_neg;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } geo_t;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] s);
    if (s > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [17:0] neg18(input logic signed [17:0] x);
    return (x == {1'b1, 17'b0}) ? {1'b0, {17{1'b1}}} : -x;
  endfunction

  // Plane registers.
  logic signed [31:0] pnt [3];
  logic signed [17:0] nrm [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pnt[0] <= '0;
      pnt[1] <= '0;
      pnt[2] <= '0;
      nrm[0] <= '0;
      nrm[1] <= 18'sd65536;
      nrm[2] <= '0;
    end else if (cfg_we) begin
      case (rpi_pkg::cfg_reg_t'(cfg_index))
        rpi_pkg::REG_POINT_X:  pnt[0] <= cfg_data;
        rpi_pkg::REG_POINT_Y:  pnt[1] <= cfg_data;
        rpi_pkg::REG_POINT_Z:  pnt[2] <= cfg_data;
        rpi_pkg::REG_NORMAL_X: nrm[0] <= cfg_data[17:0];
        rpi_pkg::REG_NORMAL_Y: nrm[1] <= cfg_data[17:0];
        rpi_pkg::REG_NORMAL_Z: nrm[2] <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Plane axes, rebuilt continuously from the registers.
  logic        [35:0] nsq [3];
  logic        [35:0] la, lb, lc, lm;
  logic signed [18:0] u_ax [3];
  logic signed [36:0] cr [6];
  logic signed [WW-1:0] w_ax [3];
  logic [RootW-1:0]   sr  [0:NIter];
  logic [SqW-1:0]     sr2 [0:NIter];
  logic [SqW-1:0]     cand [0:NIter-1];
  logic [SqW-1:0]     rad;
  logic [RootW-1:0]   root;

  assign la   = nsq[2] + nsq[1];
  assign lb   = nsq[2] + nsq[0];
  assign lc   = nsq[1] + nsq[0];
  assign rad  = SqW'(lm) << (2 * rpi_pkg::SqrtExtra);
  assign root = sr[NIter];

  always_comb begin
    for (int i = 0; i < NIter; i++) begin
      cand[i] = sr2[i] + (SqW'(sr[i]) << (rpi_pkg::SqrtTop - i + 1))
              + (SqW'(1) << (2 * (rpi_pkg::SqrtTop - i)));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nsq[i] <= 36'(36'(nrm[i]) * 36'(nrm[i]));
    end
    if (la < lb) begin
      if (lb < lc) begin
        u_ax[0] <= 19'(nrm[1]);
        u_ax[1] <= -19'(nrm[0]);
        u_ax[2] <= '0;
        lm      <= lc;
      end else begin
        u_ax[0] <= -19'(nrm[2]);
        u_ax[1] <= '0;
        u_ax[2] <= 19'(nrm[0]);
        lm      <= lb;
      end
    end else begin
      if (la < lc) begin
        u_ax[0] <= 19'(nrm[1]);
        u_ax[1] <= -19'(nrm[0]);
        u_ax[2] <= '0;
        lm      <= lc;
      end else begin
        u_ax[0] <= '0;
        u_ax[1] <= 19'(nrm[2]);
        u_ax[2] <= -19'(nrm[1]);
        lm      <= la;
      end
    end
    cr[0] <= 37'(nrm[1]) * 37'(u_ax[2]);
    cr[1] <= 37'(nrm[2]) * 37'(u_ax[1]);
    cr[2] <= 37'(nrm[2]) * 37'(u_ax[0]);
    cr[3] <= 37'(nrm[0]) * 37'(u_ax[2]);
    cr[4] <= 37'(nrm[0]) * 37'(u_ax[1]);
    cr[5] <= 37'(nrm[1]) * 37'(u_ax[0]);
    for (int i = 0; i < 3; i++) begin
      w_ax[i] <= WW'((38'(cr[2*i]) - 38'(cr[2*i+1])) >>> FB);
    end
    // Bit-serial root: one result bit per stage, r^2 kept alongside r.
    sr[0]  <= '0;
    sr2[0] <= '0;
    for (int i = 0; i < NIter; i++) begin
      if (cand[i] <= rad) begin
        sr[i+1]  <= sr[i] | (RootW'(1) << (rpi_pkg::SqrtTop - i));
        sr2[i+1] <= cand[i];
      end else begin
        sr[i+1]  <= sr[i];
        sr2[i+1] <= sr2[i];
      end
    end
  end

  // Ray pipeline.
  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic [DivLat-1:0] vd1, vd2;

  logic signed [31:0] o_in [3];
  logic signed [17:0] d_in [3];
  assign o_in[0] = origin_x;
  assign o_in[1] = origin_y;
  assign o_in[2] = origin_z;
  assign d_in[0] = dir_x;
  assign d_in[1] = dir_y;
  assign d_in[2] = dir_z;

  logic signed [31:0] o1 [3], o2 [3], o3 [3];
  logic signed [17:0] d1 [3], d2 [3], d3 [3];
  logic signed [31:0] tmin1, tmax1, tmin2, tmax2, tmin3, tmax3;
  logic signed [32:0] po1 [3];
  logic signed [35:0] nd2 [3];
  logic signed [50:0] pon2 [3];
  logic signed [37:0] den3;
  logic signed [52:0] num3;
  side_t              side4;
  logic [52:0]        a4;
  logic [37:0]        b4;
  logic               neg4;
  side_t              sd1 [DivLat];
  logic signed [31:0] q_t;
  side_t              s1o;
  logic               keep_in;

  logic               keep5, dn5;
  logic signed [31:0] t5;
  logic signed [31:0] o5 [3];
  logic signed [49:0] td5 [3];
  geo_t               geo6, geo7, geo8, geo9;
  logic signed [32:0] dd7 [3];
  logic signed [51:0] pu8 [3];
  logic signed [PwW-1:0] pw8 [3];
  logic signed [53:0] du9;
  logic signed [DvW-1:0] dv9;
  geo_t               geo10;
  logic [53:0]        au10;
  logic [DvW-1:0]     av10;
  logic               nu10, nv10;
  geo_t               sd2 [DivLat];
  logic signed [31:0] q_u, q_v;
  geo_t               go;

  assign s1o     = sd1[DivLat-1];
  assign go      = sd2[DivLat-1];
  assign keep_in = !s1o.parallel && (q_t >= s1o.tmin) && (q_t <= s1o.tmax);

  // The pipe holds only when the output is full and a result is waiting behind it.
  assign adv      = !(out_valid && out_stall && vd2[DivLat-1]);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      vd1 <= '0;
      vd2 <= '0;
    end else if (adv) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      vd1 <= {vd1[DivLat-2:0], v4};
      v5  <= vd1[DivLat-1];
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      vd2 <= {vd2[DivLat-2:0], v10};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o1[i]   <= o_in[i];
        d1[i]   <= d_in[i];
        po1[i]  <= 33'(pnt[i]) - 33'(o_in[i]);
        o2[i]   <= o1[i];
        d2[i]   <= d1[i];
        nd2[i]  <= 36'(nrm[i]) * 36'(d1[i]);
        pon2[i] <= 51'(po1[i]) * 51'(nrm[i]);
        o3[i]   <= o2[i];
        d3[i]   <= d2[i];
      end
      tmin1 <= t_min;
      tmax1 <= t_max;
      tmin2 <= tmin1;
      tmax2 <= tmax1;
      tmin3 <= tmin2;
      tmax3 <= tmax2;
      den3  <= 38'(nd2[0]) + 38'(nd2[1]) + 38'(nd2[2]);
      num3  <= 53'(pon2[0]) + 53'(pon2[1]) + 53'(pon2[2]);

      side4.parallel <= (den3 <= EpsPos) && (den3 >= EpsNeg);
      side4.den_neg  <= den3[37];
      side4.ox       <= o3[0];
      side4.oy       <= o3[1];
      side4.oz       <= o3[2];
      side4.dx       <= d3[0];
      side4.dy       <= d3[1];
      side4.dz       <= d3[2];
      side4.tmin     <= tmin3;
      side4.tmax     <= tmax3;
      a4   <= num3[52] ? 53'(-num3) : 53'(num3);
      b4   <= den3[37] ? 38'(-den3) : 38'(den3);
      neg4 <= num3[52] ^ den3[37];

      sd1[0] <= side4;
      for (int k = 1; k < DivLat; k++) begin
        sd1[k] <= sd1[k-1];
      end

      keep5  <= keep_in;
      dn5    <= s1o.den_neg;
      t5     <= q_t;
      o5[0]  <= s1o.ox;
      o5[1]  <= s1o.oy;
      o5[2]  <= s1o.oz;
      td5[0] <= 50'(q_t) * 50'(s1o.dx);
      td5[1] <= 50'(q_t) * 50'(s1o.dy);
      td5[2] <= 50'(q_t) * 50'(s1o.dz);

      geo6.keep    <= keep5;
      geo6.den_neg <= dn5;
      geo6.t       <= t5;
      geo6.px      <= sat35(35'(o5[0]) + 35'(td5[0] >>> FB));
      geo6.py      <= sat35(35'(o5[1]) + 35'(td5[1] >>> FB));
      geo6.pz      <= sat35(35'(o5[2]) + 35'(td5[2] >>> FB));

      geo7   <= geo6;
      dd7[0] <= 33'(geo6.px) - 33'(pnt[0]);
      dd7[1] <= 33'(geo6.py) - 33'(pnt[1]);
      dd7[2] <= 33'(geo6.pz) - 33'(pnt[2]);

      geo8 <= geo7;
      for (int i = 0; i < 3; i++) begin
        pu8[i] <= 52'(dd7[i]) * 52'(u_ax[i]);
        pw8[i] <= PwW'(dd7[i]) * PwW'(w_ax[i]);
      end

      geo9 <= geo8;
      du9  <= 54'(pu8[0]) + 54'(pu8[1]) + 54'(pu8[2]);
      dv9  <= DvW'(pw8[0]) + DvW'(pw8[1]) + DvW'(pw8[2]);

      geo10 <= geo9;
      au10  <= du9[53] ? 54'(-du9) : 54'(du9);
      av10  <= dv9[DvW-1] ? DvW'(-dv9) : DvW'(dv9);
      nu10  <= du9[53];
      nv10  <= dv9[DvW-1];

      sd2[0] <= geo10;
      for (int k = 1; k < DivLat; k++) begin
        sd2[k] <= sd2[k-1];
      end
    end
  end

  rpi_div u_div_t (
    .clk      (clk),
    .en       (adv),
    .dividend (rpi_pkg::DivNW'(a4) << FB),
    .divisor  (rpi_pkg::DivDW'(b4)),
    .neg      (neg4),
    .quot     (q_t)
  );

  rpi_div u_div_u (
    .clk      (clk),
    .en       (adv),
    .dividend (rpi_pkg::DivNW'(au10) << rpi_pkg::SqrtExtra),
    .divisor  (rpi_pkg::DivDW'(root)),
    .neg      (nu10),
    .quot     (q_u)
  );

  rpi_div u_div_v (
    .clk      (clk),
    .en       (adv),
    .dividend (rpi_pkg::DivNW'(av10) << rpi_pkg::SqrtExtra),
    .divisor  (rpi_pkg::DivDW'(root)),
    .neg      (nv10),
    .quot     (q_v)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= vd2[DivLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      hit_found    <= go.keep && !go.t[31];
      hit_distance <= go.keep ? go.t : '0;
      point_x      <= go.keep ? go.px : '0;
      point_y      <= go.keep ? go.py : '0;
      point_z      <= go.keep ? go.pz : '0;
      if (!go.keep) begin
        face_normal_x <= '0;
        face_normal_y <= '0;
        face_normal_z <= '0;
      end else if (go.den_neg) begin
        face_normal_x <= nrm[0];
        face_normal_y <= nrm[1];
        face_normal_z <= nrm[2];
      end else begin
        face_normal_x <= neg18(nrm[0]);
        face_normal_y <= neg18(nrm[1]);
        face_normal_z <= neg18(nrm[2]);
      end
      front_face <= go.keep && go.den_neg;
      coord_u    <= (go.keep && root != '0) ? q_u : '0;
      coord_v    <= (go.keep && root != '0) ? q_v : '0;
    end
  end

  logic fn_is_stored;
  assign fn_is_stored = (face_normal_x == nrm[0]) && (face_normal_y == nrm[1])
                      && (face_normal_z == nrm[2]);

  `RPI_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall))
  `RPI_ASSERT(a_hit_nonneg, (out_valid && hit_found) |-> !hit_distance[31])
  `RPI_ASSERT(a_front_normal, (out_valid && front_face) |-> fn_is_stored)
  `RPI_ASSERT(a_hold_keeps_last, !adv |=> vd2[DivLat-1])
  `RPI_ASSERT_NORST(a_reset_clears, rst |=> !out_valid)

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rpi_pkg::CfgIdxW-1:0] UNUSED_INDEX = 3'd6;
  localparam longint Q_ONE = 65536;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    longint o[3];
    longint d[3];
    longint t_lo;
    longint t_hi;
  } ray_t;

  typedef struct {
    longint hit;
    longint distance;
    longint pt[3];
    longint fn[3];
    longint front;
    longint cu;
    longint cv;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [17:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] t_min = '0, t_max = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit_found, front_face;
  logic signed [31:0] hit_distance, point_x, point_y, point_z, coord_u, coord_v;
  logic signed [17:0] face_normal_x, face_normal_y, face_normal_z;
  logic cfg_we = 1'b0;
  logic [rpi_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [rpi_pkg::CfgDataW-1:0] cfg_data = '0;

  ray_plane_intersect_core dut (.*);

  always #5 clk = ~clk;

  // Mirror of the plane registers.
  logic signed [31:0] plane_p[3] = '{0, 0, 0};
  logic signed [17:0] plane_n[3] = '{0, 18'sd65536, 0};

  ray_t ray_q[$];
  hit_t hit_q[$];
  int errors = 0;
  int checked = 0;
  int hits = 0;
  int fronts = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint sat(longint x, longint lo, longint hi);
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  // a * 2^sh / b, truncated toward zero and saturated to 32 bits.
  function automatic longint scaled_quot(longint a, longint b, int sh);
    bit neg;
    longint unsigned ma, mb, q0, r, q;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    q0 = ma / mb;
    r = ma % mb;
    if (q0 > ((64'd1 << 31) >> sh)) q = 64'd1 << 32;
    else q = (q0 << sh) + (r << sh) / mb;
    if (neg) return q >= (64'd1 << 31) ? I32_MIN : -longint'(q);
    return q > 64'd2147483647 ? I32_MAX : longint'(q);
  endfunction

  function automatic longint unsigned axis_len(longint unsigned rad);
    longint unsigned r, c;
    int b;
    r = 0;
    for (int i = 0; i < rpi_pkg::SqrtIter; i++) begin
      b = rpi_pkg::SqrtTop - i;
      if (b < 0) break;
      c = r | (64'd1 << b);
      if (c * c <= rad) r = c;
    end
    return r;
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t e;
    longint p[3], n[3], u[3], w[3], pt[3];
    longint den, num, t, la, lb, lc, lm, du, dv, dd;
    longint unsigned len;
    e = '{default: 0};
    for (int i = 0; i < 3; i++) begin
      p[i] = plane_p[i];
      n[i] = plane_n[i];
    end
    den = n[0] * r.d[0] + n[1] * r.d[1] + n[2] * r.d[2];
    if (den <= rpi_pkg::ParEps && den >= -rpi_pkg::ParEps) return e;
    num = (p[0] - r.o[0]) * n[0] + (p[1] - r.o[1]) * n[1] + (p[2] - r.o[2]) * n[2];
    t = scaled_quot(num, den, rpi_pkg::FracBits);
    if (t < r.t_lo || t > r.t_hi) return e;
    e.hit = t >= 0;
    e.distance = t;
    for (int i = 0; i < 3; i++) begin
      pt[i] = sat(r.o[i] + ((t * r.d[i]) >>> rpi_pkg::FracBits), I32_MIN, I32_MAX);
      e.pt[i] = pt[i];
      e.fn[i] = den < 0 ? n[i] : sat(-n[i], -131072, 131071);
    end
    e.front = den < 0;
    la = n[2] * n[2] + n[1] * n[1];
    lb = n[2] * n[2] + n[0] * n[0];
    lc = n[1] * n[1] + n[0] * n[0];
    if (la < lb) begin
      u = '{-n[2], 0, n[0]};
      lm = lb;
    end else begin
      u = '{0, n[2], -n[1]};
      lm = la;
    end
    if (lm < lc) begin
      u = '{n[1], -n[0], 0};
      lm = lc;
    end
    len = axis_len(longint'(lm) << (2 * rpi_pkg::SqrtExtra));
    if (len != 0) begin
      w[0] = (n[1] * u[2] - n[2] * u[1]) >>> rpi_pkg::FracBits;
      w[1] = (n[2] * u[0] - n[0] * u[2]) >>> rpi_pkg::FracBits;
      w[2] = (n[0] * u[1] - n[1] * u[0]) >>> rpi_pkg::FracBits;
      du = 0;
      dv = 0;
      for (int i = 0; i < 3; i++) begin
        dd = pt[i] - p[i];
        du += dd * u[i];
        dv += dd * w[i];
      end
      e.cu = scaled_quot(du, longint'(len), rpi_pkg::SqrtExtra);
      e.cv = scaled_quot(dv, longint'(len), rpi_pkg::SqrtExtra);
    end
    return e;
  endfunction

  // Sender: one beat per ray, with a random gap drawn for each ray unless no_gaps is set.
  ray_t cur;
  int gap = 0;
  bit busy;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        hit_q.push_back(trace_ray(cur));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (ray_q.size() > 0) begin
          cur = ray_q.pop_front();
          origin_x <= cur.o[0];
          origin_y <= cur.o[1];
          origin_z <= cur.o[2];
          dir_x <= cur.d[0];
          dir_y <= cur.d[1];
          dir_z <= cur.d[2];
          t_min <= cur.t_lo;
          t_max <= cur.t_hi;
          in_valid <= 1'b1;
          gap = no_gaps ? 0 : $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp, longint act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      errors++;
    end
  endtask

  // Receiver: checks each result beat and draws its own stall per beat.
  int hold = 0;
  hit_t e;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          errors++;
        end else begin
          e = hit_q.pop_front();
          checked++;
          hits += e.hit;
          fronts += e.front;
          check_field("hit_found", e.hit, hit_found);
          check_field("hit_distance", e.distance, hit_distance);
          check_field("point_x", e.pt[0], point_x);
          check_field("point_y", e.pt[1], point_y);
          check_field("point_z", e.pt[2], point_z);
          check_field("face_normal_x", e.fn[0], face_normal_x);
          check_field("face_normal_y", e.fn[1], face_normal_y);
          check_field("face_normal_z", e.fn[2], face_normal_z);
          check_field("front_face", e.front, front_face);
          check_field("coord_u", e.cu, coord_u);
          check_field("coord_v", e.cv, coord_v);
        end
        hold = no_gaps ? 0 : $urandom_range(0, 18);
      end
      if (hold_req) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [rpi_pkg::CfgIdxW-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    if (idx <= rpi_pkg::REG_POINT_Z) plane_p[idx] = val[31:0];
    else if (idx <= rpi_pkg::REG_NORMAL_Z) plane_n[idx - rpi_pkg::REG_NORMAL_X] = val[17:0];
    @(posedge clk);
  endtask

  task automatic set_plane(longint px, longint py, longint pz,
                           longint nx, longint ny, longint nz);
    write_reg(rpi_pkg::REG_POINT_X, px);
    write_reg(rpi_pkg::REG_POINT_Y, py);
    write_reg(rpi_pkg::REG_POINT_Z, pz);
    write_reg(rpi_pkg::REG_NORMAL_X, nx);
    write_reg(rpi_pkg::REG_NORMAL_Y, ny);
    write_reg(rpi_pkg::REG_NORMAL_Z, nz);
    write_reg(UNUSED_INDEX, $urandom);
    cfg_we <= 1'b0;
    // The block rebuilds its plane axes after a write.
    repeat (30) @(posedge clk);
  endtask

  function automatic ray_t mk(longint ox, longint oy, longint oz, longint dx,
                              longint dy, longint dz, longint lo, longint hi);
    ray_t r;
    r.o = '{ox, oy, oz};
    r.d = '{dx, dy, dz};
    r.t_lo = lo;
    r.t_hi = hi;
    return r;
  endfunction

  function automatic longint rand_dir();
    case ($urandom_range(0, 5))
      0: return longint'($urandom_range(0, 16)) - 8;
      1: return 0;
      2: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return longint'($urandom_range(0, 131072)) - Q_ONE;
    endcase
  endfunction

  function automatic longint rand_coord();
    if ($urandom_range(0, 2) == 0) return longint'(int'($urandom));
    return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = rand_coord();
      r.d[i] = rand_dir();
    end
    case ($urandom_range(0, 3))
      0: r.t_lo = 0;
      1: r.t_lo = I32_MIN;
      2: r.t_lo = longint'(int'($urandom));
      default: r.t_lo = -longint'($urandom_range(0, 1 << 20));
    endcase
    case ($urandom_range(0, 2))
      0: r.t_hi = I32_MAX;
      1: r.t_hi = longint'(int'($urandom));
      default: r.t_hi = $urandom_range(0, 1 << 24);
    endcase
    return r;
  endfunction

  task automatic run_rays(int count);
    for (int i = 0; i < count; i++) ray_q.push_back(rand_ray());
    wait (ray_q.size() == 0 && !in_valid && hit_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  longint rn[3];
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (30) @(posedge clk);

    // Reset plane: y = 0 facing +y.
    ray_q.push_back(mk(0, 10 * Q_ONE, 0, 0, -Q_ONE, 0, 0, I32_MAX));
    ray_q.push_back(mk(3 * Q_ONE, 10 * Q_ONE, -Q_ONE, 0, Q_ONE, 0, I32_MIN, I32_MAX));
    ray_q.push_back(mk(0, 10 * Q_ONE, 0, Q_ONE, 0, -Q_ONE, I32_MIN, I32_MAX));
    ray_q.push_back(mk(0, 10 * Q_ONE, 0, 0, -Q_ONE, 0, 0, 5 * Q_ONE));
    ray_q.push_back(mk(0, 10 * Q_ONE, 0, 0, -Q_ONE, 0, 11 * Q_ONE, I32_MAX));
    ray_q.push_back(mk(0, 10 * Q_ONE, 0, 0, -Q_ONE, 0, 10 * Q_ONE, 10 * Q_ONE));
    ray_q.push_back(mk(I32_MAX, I32_MAX, I32_MAX, Q_ONE, -Q_ONE, Q_ONE, I32_MIN, I32_MAX));
    ray_q.push_back(mk(I32_MIN, I32_MIN, I32_MIN, -Q_ONE, 1, -Q_ONE, I32_MIN, I32_MAX));
    ray_q.push_back(mk(0, I32_MAX, 0, Q_ONE, -1, 0, I32_MIN, I32_MAX));
    ray_q.push_back(mk(-Q_ONE, -5 * Q_ONE, Q_ONE, 300, Q_ONE, -300, 0, I32_MAX));
    ray_q.push_back(mk(0, -Q_ONE, 0, 0, Q_ONE, 0, I32_MAX, I32_MAX));
    ray_q.push_back(mk(7, 9 * Q_ONE, -7, -Q_ONE, -Q_ONE, Q_ONE, I32_MIN, I32_MIN));
    ray_q.push_back(mk(1, 1, 1, 0, 0, 0, I32_MIN, I32_MAX));
    run_rays(200);

    // Receiver holds off while rays keep coming, so the pipeline backs up.
    set_plane(Q_ONE, -2 * Q_ONE, 0, Q_ONE, 0, 0);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    run_rays(250);
    no_gaps = 1'b0;

    set_plane(I32_MAX, I32_MAX, I32_MAX, 0, 0, -Q_ONE);
    run_rays(250);
    set_plane(I32_MIN, I32_MIN, I32_MIN, -Q_ONE, 0, 0);
    run_rays(250);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) rn[i] = longint'($urandom_range(0, 131072)) - Q_ONE;
      set_plane(rand_coord(), rand_coord(), rand_coord(), rn[0], rn[1], rn[2]);
      run_rays(250);
    end
    // Tiny normal: many rays fall inside the parallel threshold.
    set_plane(-3 * Q_ONE, Q_ONE, 2, 3, -1, 2);
    run_rays(200);
    // Zero normal: every ray is parallel and the u axis is empty.
    set_plane(0, 0, 0, 0, 0, 0);
    run_rays(50);

    $display("Checked %0d result beats over 8 plane settings: %0d hits, %0d front faces.",
             checked, hits, fronts);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rpi_pkg.sv
rtl/rpi_div.sv
rtl/ray_plane_intersect_core.sv
verif/tb.sv
